/* sv/assert_macros.svh */
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication with reset disable
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must be followed by a consequence on the next edge
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* sv/lerb_pkg.sv */
`default_nettype none
package lerb_pkg;
    localparam int NodeSlots = 64;
    localparam int RegSlots = 16;
    localparam int CycleSlots = 256;
    localparam int NodeW = 6;
    localparam int CntW = 7;
    localparam int RegW = 4;
    localparam int RegCntW = 5;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_NODE  = 2'd1,
        OP_EDGE  = 2'd2,
        OP_RUN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NO_REGS = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE_RD, S_EDGE_WR, S_SORT_INIT, S_SORT_RD, S_SORT_KEY, S_SORT_CMP,
        S_BIND_RD, S_BIND_NODE, S_BIND_CHK, S_BIND_MARK, S_EMIT_RD, S_EMIT
    } state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load_in;
        logic clear;
        logic add_node;
        logic edge_rd;
        logic edge_wr;
        logic walk_init;
        logic sort_init;
        logic sort_rd;
        logic sort_key;
        logic sort_cmp;
        logic bind_rd;
        logic bind_node;
        logic bind_chk;
        logic bind_mark;
        logic emit_rd;
        logic emit_adv;
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       sort_done;
        logic       init_done;
        logic       bind_done;
        logic       skip_node;
        logic       reg_found;
        logic       chk_done;
        logic       emit_last;
        logic       no_regs;
    } stat_t;
endpackage
`default_nettype wire

/* sv/lerb_datapath.sv */
`default_nettype none
module lerb_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lerb_pkg::cmd_t     cmd,
    output lerb_pkg::stat_t         stat,
    input  wire logic [1:0]         s_operation,
    input  wire logic [7:0]         s_schedule_cycle,
    input  wire logic               s_produces_value,
    input  wire logic [5:0]         s_from_node,
    input  wire logic [5:0]         s_to_node,
    output logic [3:0]              m_register_index,
    output logic [5:0]              m_bound_node,
    output logic [7:0]              m_from_cycle,
    output logic [8:0]              m_to_cycle,
    output logic                    m_long_lived,
    output logic [1:0]              m_status
);
    import lerb_pkg::*;

    logic [7:0]       start_mem [NodeSlots];
    logic [8:0]       end_mem   [NodeSlots];
    logic             prod_mem  [NodeSlots];
    logic [NodeW-1:0] order_mem [NodeSlots];
    logic [CycleSlots-1:0] occ_reg [RegSlots];
    logic [NodeW+17-1:0]   bind_mem [RegSlots];

    logic [1:0]       op_reg;
    logic [7:0]       cyc_reg;
    logic             prod_reg;
    logic [NodeW-1:0] src_reg, dst_reg;
    logic [CntW-1:0]  total_reg;
    logic [RegCntW-1:0] used_reg;
    logic [CntW-1:0]  i_reg, j_reg;
    logic [NodeW-1:0] oi_reg, oj_reg;
    logic [7:0]       si_reg, sj_reg;
    logic [7:0]       bs_reg;
    logic [8:0]       be_reg;
    logic             bp_reg;
    logic [NodeW-1:0] bn_reg;
    logic [RegCntW-1:0] r_reg;
    logic [NodeW+17-1:0] emit_reg;

    logic [8:0] edge_src_end_reg;
    logic [7:0] edge_dst_start_reg;

    // interval mask over the cycles from the node's start to its end, inclusive
    logic [CycleSlots-1:0] mask;
    always_comb begin
        for (int k = 0; k < CycleSlots; k++) begin
            mask[k] = (9'(k) >= {1'b0, bs_reg}) && (9'(k) <= be_reg);
        end
    end

    logic occ_hit;
    assign occ_hit = |(occ_reg[r_reg[RegW-1:0]] & mask);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            used_reg  <= '0;
        end else begin
            if (cmd.load_in) begin
                op_reg   <= s_operation;
                cyc_reg  <= s_schedule_cycle;
                prod_reg <= s_produces_value;
                src_reg  <= s_from_node;
                dst_reg  <= s_to_node;
            end
            if (cmd.clear) begin
                total_reg <= '0;
                used_reg  <= '0;
            end
            if (cmd.add_node && total_reg != CntW'(NodeSlots)) begin
                start_mem[total_reg[NodeW-1:0]] <= cyc_reg;
                end_mem[total_reg[NodeW-1:0]]   <= {1'b0, cyc_reg} + 9'd1;
                prod_mem[total_reg[NodeW-1:0]]  <= prod_reg;
                total_reg <= total_reg + 1'b1;
            end
            if (cmd.edge_rd) begin
                edge_src_end_reg   <= end_mem[src_reg];
                edge_dst_start_reg <= start_mem[dst_reg];
            end
            if (cmd.edge_wr && {1'b0, src_reg} < total_reg && {1'b0, dst_reg} < total_reg
                && {1'b0, edge_dst_start_reg} > edge_src_end_reg) begin
                end_mem[src_reg] <= {1'b0, edge_dst_start_reg};
            end
            // restart the walk indexes
            if (cmd.walk_init) begin
                i_reg <= '0;
                r_reg <= '0;
            end
            if (cmd.sort_init) begin
                if (i_reg < total_reg) begin
                    order_mem[i_reg[NodeW-1:0]] <= i_reg[NodeW-1:0];
                end
                if (i_reg < CntW'(RegSlots)) occ_reg[i_reg[RegW-1:0]] <= '0;
                used_reg <= '0;
                i_reg <= (i_reg == CntW'(NodeSlots)) ? '0 : i_reg + 1'b1;
                j_reg <= 7'd1;
            end
            if (cmd.sort_rd) begin
                oi_reg <= order_mem[i_reg[NodeW-1:0]];
                oj_reg <= order_mem[j_reg[NodeW-1:0]];
            end
            if (cmd.sort_key) begin
                si_reg <= start_mem[oi_reg];
                sj_reg <= start_mem[oj_reg];
            end
            if (cmd.sort_cmp) begin
                if (si_reg > sj_reg) begin
                    order_mem[i_reg[NodeW-1:0]] <= oj_reg;
                    order_mem[j_reg[NodeW-1:0]] <= oi_reg;
                end
                if (j_reg + 1'b1 >= total_reg) begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= i_reg + 7'd2;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            if (cmd.bind_rd) begin
                bn_reg <= order_mem[i_reg[NodeW-1:0]];
            end
            if (cmd.bind_node) begin
                bs_reg <= start_mem[bn_reg];
                be_reg <= end_mem[bn_reg];
                bp_reg <= prod_mem[bn_reg];
                r_reg  <= '0;
            end
            if (cmd.bind_chk) begin
                if (stat.skip_node) begin
                    i_reg <= i_reg + 1'b1;
                end else begin
                    r_reg <= r_reg + 1'b1;
                    if (stat.chk_done) i_reg <= i_reg + 1'b1;
                end
            end
            if (cmd.bind_mark) begin
                occ_reg[r_reg[RegW-1:0]] <= occ_reg[r_reg[RegW-1:0]] | mask;
                bind_mem[r_reg[RegW-1:0]] <= {bn_reg, bs_reg, be_reg};
                if (r_reg == used_reg) used_reg <= used_reg + 1'b1;
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.emit_rd) begin
                emit_reg <= bind_mem[r_reg[RegW-1:0]];
            end
            if (cmd.emit_adv) r_reg <= r_reg + 1'b1;
        end
    end

    always_comb begin
        stat.op        = op_reg;
        stat.empty     = (total_reg == '0);
        stat.init_done = (i_reg == CntW'(NodeSlots));
        stat.sort_done = (i_reg + 1'b1 >= total_reg);
        stat.bind_done = (i_reg >= total_reg);
        stat.skip_node = !bp_reg;
        stat.reg_found = (r_reg < used_reg) ? !occ_hit : (r_reg < RegCntW'(RegSlots));
        stat.chk_done  = (r_reg >= used_reg);
        stat.emit_last = (r_reg + 1'b1 == used_reg);
        stat.no_regs   = (used_reg == '0);
    end

    logic [NodeW-1:0] e_node;
    logic [7:0]       e_s;
    logic [8:0]       e_e;
    assign {e_node, e_s, e_e} = emit_reg;
    assign m_register_index = stat.no_regs ? '0 : r_reg[RegW-1:0];
    assign m_bound_node     = stat.no_regs || stat.empty ? '0 : e_node;
    assign m_from_cycle     = stat.no_regs || stat.empty ? '0 : e_s;
    assign m_to_cycle       = stat.no_regs || stat.empty ? '0 : e_e;
    assign m_long_lived     = stat.no_regs || stat.empty ? 1'b0 : (e_e > {1'b0, e_s} + 9'd1);
    assign m_status         = stat.empty ? ST_EMPTY : (stat.no_regs ? ST_NO_REGS : ST_OK);
endmodule
`default_nettype wire

/* sv/lerb_ctrl.sv */
`default_nettype none
module lerb_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic                m_last,
    output lerb_pkg::cmd_t      cmd,
    input  wire lerb_pkg::stat_t stat
);
    import lerb_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    logic busy_reg, busy_next;
    always_ff @(posedge aclk) begin
        if (!aresetn) busy_reg <= 1'b0;
        else          busy_reg <= busy_next;
    end

    always_comb begin
        state_next = state_reg;
        busy_next  = busy_reg;
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        m_last  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (busy_reg) begin
                    busy_next = 1'b0;
                    case (stat.op)
                        OP_CLEAR: cmd.clear = 1'b1;
                        OP_NODE:  cmd.add_node = 1'b1;
                        OP_EDGE:  state_next = S_EDGE_RD;
                        OP_RUN: begin
                            if (stat.empty) state_next = S_EMIT;
                            else begin
                                cmd.walk_init = 1'b1;
                                state_next = S_SORT_INIT;
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        cmd.load_in = 1'b1;
                        busy_next = 1'b1;
                    end
                end
            end
            S_EDGE_RD: begin
                cmd.edge_rd = 1'b1;
                state_next = S_EDGE_WR;
            end
            S_EDGE_WR: begin
                cmd.edge_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_SORT_INIT: begin
                cmd.sort_init = 1'b1;
                if (stat.init_done) state_next = S_SORT_RD;
            end
            S_SORT_RD: begin
                if (stat.sort_done) begin
                    cmd.walk_init = 1'b1;
                    state_next = S_BIND_RD;
                end else begin
                    cmd.sort_rd = 1'b1;
                    state_next = S_SORT_KEY;
                end
            end
            S_SORT_KEY: begin
                cmd.sort_key = 1'b1;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                cmd.sort_cmp = 1'b1;
                state_next = S_SORT_RD;
            end
            S_BIND_RD: begin
                if (stat.bind_done) begin
                    cmd.walk_init = 1'b1;
                    state_next = stat.no_regs ? S_EMIT : S_EMIT_RD;
                end else begin
                    cmd.bind_rd = 1'b1;
                    state_next = S_BIND_NODE;
                end
            end
            S_BIND_NODE: begin
                cmd.bind_node = 1'b1;
                state_next = S_BIND_CHK;
            end
            S_BIND_CHK: begin
                if (stat.skip_node) begin
                    cmd.bind_chk = 1'b1;
                    state_next = S_BIND_RD;
                end else if (stat.reg_found) state_next = S_BIND_MARK;
                else begin
                    cmd.bind_chk = 1'b1;
                    if (stat.chk_done) state_next = S_BIND_RD;
                end
            end
            S_BIND_MARK: begin
                cmd.bind_mark = 1'b1;
                state_next = S_BIND_RD;
            end
            S_EMIT_RD: begin
                cmd.emit_rd = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                m_valid = 1'b1;
                m_last  = stat.empty || stat.no_regs || stat.emit_last;
                if (m_ready) begin
                    if (m_last) state_next = S_IDLE;
                    else begin
                        cmd.emit_adv = 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* sv/left_edge_register_binder_unit.sv */
// Left-edge register binder. Each transaction on the s_ side is one
// command: clear, add node, add edge, or run. A run initialises the order
// and occupancy tables, performs the exchange sort over the node order
// memory (read two order entries, read their start cycles, compare and
// swap), then binds each value-producing node in start order, testing one
// register's occupancy word per cycle, and finally emits one m_ transaction
// per used register, with m_last on the final one (a single status one if
// none is used). Only one command is in progress at a time.
`default_nettype none
module left_edge_register_binder_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_operation,
    input  wire logic [7:0] s_schedule_cycle,
    input  wire logic       s_produces_value,
    input  wire logic [5:0] s_from_node,
    input  wire logic [5:0] s_to_node,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [3:0]      m_register_index,
    output logic [5:0]      m_bound_node,
    output logic [7:0]      m_from_cycle,
    output logic [8:0]      m_to_cycle,
    output logic            m_long_lived,
    output logic [1:0]      m_status,
    output logic            m_last
);
    import lerb_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencing of commands, sort and binding walk
    lerb_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_last,
        .cmd, .stat
    );

    // node tables, order memory, occupancy and binding storage
    lerb_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .s_operation, .s_schedule_cycle, .s_produces_value, .s_from_node, .s_to_node,
        .m_register_index, .m_bound_node, .m_from_cycle, .m_to_cycle,
        .m_long_lived, .m_status
    );
endmodule
`default_nettype wire

/* sv/lerb_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module lerb_port_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_status,
    input wire logic       m_last
);
    import lerb_pkg::*;
    `ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "m_valid dropped")
    `ASSERT_CLK(a_no_overlap, aclk, aresetn, m_valid |-> !s_ready, "input taken during output")
    `ASSERT_CLK(a_err_last, aclk, aresetn, (m_valid && m_status != ST_OK) |-> m_last, "status result not last")
endmodule
bind left_edge_register_binder_unit lerb_port_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_status, .m_last
);
`default_nettype wire

/* tb/sv/lerb_checker.sv */
`timescale 1ns / 100ps
module lerb_checker
    import lerb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [1:0] s_operation,
    input  wire logic [7:0] s_schedule_cycle,
    input  wire logic       s_produces_value,
    input  wire logic [5:0] s_from_node,
    input  wire logic [5:0] s_to_node,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [3:0] m_register_index,
    input  wire logic [5:0] m_bound_node,
    input  wire logic [7:0] m_from_cycle,
    input  wire logic [8:0] m_to_cycle,
    input  wire logic       m_long_lived,
    input  wire logic [1:0] m_status,
    input  wire logic       m_last,
    output int              fail_count,
    output int              pending
);
    typedef struct packed {
        logic [3:0] reg_idx;
        logic [5:0] node;
        logic [7:0] from_c;
        logic [8:0] to_c;
        logic       long_l;
        status_t    status;
        logic       last;
    } binding_rpt_t;

    binding_rpt_t expected_bindings[$];

    logic [7:0] lt_start[NodeSlots];
    logic [8:0] lt_end[NodeSlots];
    logic       lt_produces[NodeSlots];
    int         nodes_loaded;

    // left-edge allocation over the loaded graph, pushes one report per used register or a single no-registers report
    function automatic void predict_binding();
        int         order[NodeSlots];
        logic [255:0] occ[RegSlots];
        int         reg_owner[RegSlots];
        int         used;
        int         tmp;
        int         n;
        int         pick;
        bit         free;
        binding_rpt_t rpt;
        used = 0;
        for (int r = 0; r < RegSlots; r++) occ[r] = '0;
        for (int i = 0; i < nodes_loaded; i++) order[i] = i;
        for (int i = 0; i + 1 < nodes_loaded; i++)
            for (int j = i + 1; j < nodes_loaded; j++)
                if (lt_start[order[i]] > lt_start[order[j]]) begin
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
        for (int i = 0; i < nodes_loaded; i++) begin
            n = order[i];
            if (!lt_produces[n]) continue;
            pick = -1;
            for (int r = 0; r < used && pick < 0; r++) begin
                free = 1'b1;
                for (int c = lt_start[n]; c <= lt_end[n]; c++)
                    if (c < CycleSlots && occ[r][c]) free = 1'b0;
                if (free) pick = r;
            end
            if (pick < 0 && used < RegSlots) begin
                pick = used;
                used++;
            end
            if (pick < 0) continue;
            for (int c = lt_start[n]; c <= lt_end[n] && c < CycleSlots; c++)
                occ[pick][c] = 1'b1;
            reg_owner[pick] = n;
        end
        if (used == 0) begin
            rpt = '0;
            rpt.status = ST_NO_REGS;
            rpt.last = 1'b1;
            expected_bindings.push_back(rpt);
        end else begin
            for (int r = 0; r < used; r++) begin
                n = reg_owner[r];
                rpt.reg_idx = r[3:0];
                rpt.node = n[5:0];
                rpt.from_c = lt_start[n];
                rpt.to_c = lt_end[n];
                rpt.long_l = (lt_end[n] > {1'b0, lt_start[n]} + 9'd1);
                rpt.status = ST_OK;
                rpt.last = (r == used - 1);
                expected_bindings.push_back(rpt);
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            nodes_loaded = 0;
        end else if (s_valid && s_ready) begin
            case (op_t'(s_operation))
                OP_CLEAR: nodes_loaded = 0;
                OP_NODE: begin
                    if (nodes_loaded < NodeSlots) begin
                        lt_start[nodes_loaded] = s_schedule_cycle;
                        lt_end[nodes_loaded] = {1'b0, s_schedule_cycle} + 9'd1;
                        lt_produces[nodes_loaded] = s_produces_value;
                        nodes_loaded = nodes_loaded + 1;
                    end
                end
                OP_EDGE: begin
                    if (s_from_node < nodes_loaded && s_to_node < nodes_loaded
                        && {1'b0, lt_start[s_to_node]} > lt_end[s_from_node])
                        lt_end[s_from_node] = {1'b0, lt_start[s_to_node]};
                end
                default: begin
                    if (nodes_loaded == 0) begin
                        expected_bindings.push_back('{0, 0, 0, 0, 0, ST_EMPTY, 1});
                    end else begin
                        predict_binding();
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        binding_rpt_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bindings.size() == 0) begin
                if (fail_count < 10)
                    $display("unexpected result: reg %0d node %0d", m_register_index,
                             m_bound_node);
                fail_count = fail_count + 1;
            end else begin
                want = expected_bindings.pop_front();
                if (want.reg_idx !== m_register_index || want.node !== m_bound_node
                    || want.from_c !== m_from_cycle || want.to_c !== m_to_cycle
                    || want.long_l !== m_long_lived || want.status !== m_status
                    || want.last !== m_last) begin
                    if (fail_count < 10)
                        $display({"mismatch: exp reg %0d node %0d from %0d to %0d long %0d",
                                  " st %0d last %0d / got %0d %0d %0d %0d %0d %0d %0d"},
                                 want.reg_idx, want.node, want.from_c, want.to_c,
                                 want.long_l, want.status, want.last, m_register_index,
                                 m_bound_node, m_from_cycle, m_to_cycle, m_long_lived,
                                 m_status, m_last);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    initial fail_count = 0;
    assign pending = expected_bindings.size();
endmodule

/* tb/sv/left_edge_register_binder_unit_tb.sv */
`timescale 1ns / 100ps
module left_edge_register_binder_unit_tb;
    import lerb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_operation = OP_CLEAR;
    logic [7:0] s_schedule_cycle = '0;
    logic       s_produces_value = 1'b0;
    logic [5:0] s_from_node = '0;
    logic [5:0] s_to_node = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_register_index;
    logic [5:0] m_bound_node;
    logic [7:0] m_from_cycle;
    logic [8:0] m_to_cycle;
    logic       m_long_lived;
    logic [1:0] m_status;
    logic       m_last;

    int fail_count;
    int pending;
    int items_sent = 0;
    int cycle_count = 0;
    // idling percentages for the current phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // receiver hold-off request, counted down in the receiver process
    int hold_off_len = 0;
    int hold_left = 0;

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    left_edge_register_binder_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_schedule_cycle(s_schedule_cycle), .s_produces_value(s_produces_value),
        .s_from_node(s_from_node), .s_to_node(s_to_node),
        .m_valid(m_valid), .m_ready(m_ready), .m_register_index(m_register_index),
        .m_bound_node(m_bound_node), .m_from_cycle(m_from_cycle), .m_to_cycle(m_to_cycle),
        .m_long_lived(m_long_lived), .m_status(m_status), .m_last(m_last)
    );

    lerb_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_schedule_cycle(s_schedule_cycle), .s_produces_value(s_produces_value),
        .s_from_node(s_from_node), .s_to_node(s_to_node),
        .m_valid(m_valid), .m_ready(m_ready), .m_register_index(m_register_index),
        .m_bound_node(m_bound_node), .m_from_cycle(m_from_cycle), .m_to_cycle(m_to_cycle),
        .m_long_lived(m_long_lived), .m_status(m_status), .m_last(m_last),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_off_len > 0) begin
            hold_left = hold_off_len;
            hold_off_len = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // cycle budget, covers the slowest run with all stalls
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // one transaction on the command side, with an optional idle gap first
    task automatic send_cmd(op_t op, logic [7:0] cyc, logic prod, logic [5:0] src,
                            logic [5:0] dst);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_schedule_cycle <= cyc;
        s_produces_value <= prod;
        s_from_node <= src;
        s_to_node <= dst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic add_node(logic [7:0] cyc, logic prod);
        send_cmd(OP_NODE, cyc, prod, 6'd0, 6'd0);
    endtask

    task automatic add_edge(logic [5:0] src, logic [5:0] dst);
        send_cmd(OP_EDGE, 8'd0, 1'b0, src, dst);
    endtask

    task automatic run_bind();
        send_cmd(OP_RUN, 8'($urandom), 1'($urandom), 6'($urandom), 6'($urandom));
    endtask

    // well-formed graph: clear, nodes, edges among them plus some strays, run
    task automatic random_graph(int node_cnt, bit wide_cycles);
        int base;
        int edge_cnt;
        base = $urandom_range(0, 200);
        send_cmd(OP_CLEAR, 8'($urandom), 1'($urandom), 6'($urandom), 6'($urandom));
        for (int i = 0; i < node_cnt; i++)
            add_node(wide_cycles ? 8'($urandom) : 8'(base + $urandom_range(0, 30)),
                     $urandom_range(99) < 80);
        edge_cnt = $urandom_range(0, node_cnt);
        for (int i = 0; i < edge_cnt; i++) begin
            if ($urandom_range(9) == 0)
                add_edge(6'($urandom), 6'($urandom));
            else
                add_edge(6'($urandom_range(0, node_cnt - 1)),
                         6'($urandom_range(0, node_cnt - 1)));
        end
        run_bind();
        if ($urandom_range(3) == 0) run_bind();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty graph, graph with no value producers
        run_bind();
        add_node(8'd0, 1'b0);
        run_bind();
        // edge arriving before its destination node is ignored
        send_cmd(OP_CLEAR, 8'hff, 1'b1, 6'h3f, 6'h3f);
        add_node(8'd0, 1'b1);
        add_edge(6'd0, 6'd1);
        add_node(8'd255, 1'b1);
        add_node(8'd0, 1'b1);
        add_node(8'd1, 1'b1);
        add_edge(6'd0, 6'd1);
        add_edge(6'd3, 6'd1);
        add_edge(6'd63, 6'd0);
        add_edge(6'd1, 6'd63);
        add_node(8'd128, 1'b0);
        add_edge(6'd2, 6'd4);
        run_bind();
        run_bind();

        // table full, register exhaustion, high node indexes on edges
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_cmd(OP_CLEAR, 8'd0, 1'b0, 6'd0, 6'd0);
        for (int i = 0; i < NodeSlots + 2; i++)
            add_node(8'($urandom_range(0, 20)), 1'b1);
        for (int i = 0; i < 8; i++)
            add_edge(6'($urandom_range(32, 63)), 6'($urandom_range(32, 63)));
        add_edge(6'd63, 6'd0);
        // long enough to outlast the full-table run and stall the next command
        hold_off_len = 12000;
        run_bind();
        run_bind();

        // random phases with different idling
        while (items_sent < 360) begin
            case ((items_sent / 40) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if ($urandom_range(9) == 0)
                send_cmd(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                         6'($urandom), 6'($urandom));
            else if ($urandom_range(19) == 0)
                random_graph($urandom_range(17, 40), 1'($urandom_range(1)));
            else
                random_graph($urandom_range(1, 12), $urandom_range(3) == 0);
        end
        s_valid <= 1'b0;

        // let the checker see the last accepted command first
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+sv
sv/lerb_pkg.sv
sv/lerb_datapath.sv
sv/lerb_ctrl.sv
sv/left_edge_register_binder_unit.sv
sv/lerb_checker.sv
tb/sv/lerb_checker.sv
tb/sv/left_edge_register_binder_unit_tb.sv
